FILE: design/assert_macros.svh
// Assertion macros, included by ray_segment_intersection.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/rsi_pkg.sv
// Shared constants and types of the ray versus segment intersection block.
// Used by rsi_front, rsi_div and ray_segment_intersection; depends on nothing.
package rsi_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  // Ray distance is unsigned Q16.16.
  localparam int DIST_W    = 32;
  localparam int DIST_FRAC = 16;

  localparam int CFG_IDX_W = 2;

  // Division lanes that share one denominator.
  localparam int LANES  = 3;
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_U = 2;

  typedef enum logic [1:0] {
    OUT_HIT      = 2'd0,
    OUT_PARALLEL = 2'd1,
    OUT_OUTSIDE  = 2'd2,
    OUT_BEHIND   = 2'd3
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X   = 2'd0,
    REG_START_Y   = 2'd1,
    REG_THROUGH_X = 2'd2,
    REG_THROUGH_Y = 2'd3
  } cfg_reg_t;

endpackage

FILE: design/ray_segment_intersection.sv
// Top level of the ray versus wall segment intersection pipeline: ray
// registers, front stages, divider, output register. Uses rsi_pkg, rsi_front,
// rsi_div and assert_macros.svh.
//
//  channel  direction  contents
//  s_*      in         one wall segment per beat
//  m_*      out        outcome, hit point and ray distance per beat
//  cfg_*    in         ray start and through point registers
//
// One segment is taken per cycle while no beat is held on m_*; the divider
// resolves one quotient bit of the Q16.16 distance per stage.
// Reset clears the ray registers and all valid bits.
// A beat held on m_* freezes the whole pipeline; s_tready follows it.
`include "assert_macros.svh"

module ray_segment_intersection #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
  localparam int IN_TW  = ((4 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_RW = 2 * COORD_WIDTH + 2 + rsi_pkg::DIST_W,
  localparam int OUT_TW = ((OUT_RW + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // seg_a_x, seg_a_y, seg_b_x, seg_b_y, zero fill
  input  logic [IN_TW-1:0]              s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // outcome, hit_x, hit_y, ray_distance, zero fill
  output logic [OUT_TW-1:0]             m_tdata,
  input  logic                          cfg_we,
  input  logic [rsi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data
);

  localparam int W      = COORD_WIDTH;
  localparam int QW     = rsi_pkg::DIST_W;
  localparam int DEN_W  = 2 * W + 1;
  localparam int NUM_W  = DEN_W + QW;
  localparam int SIDE_W = 2 * W + 5;

  logic signed [W-1:0] start_x, start_y, through_x, through_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x   <= '0;
      start_y   <= '0;
      through_x <= '0;
      through_y <= '0;
    end else if (cfg_we) begin
      case (rsi_pkg::cfg_reg_t'(cfg_index))
        rsi_pkg::REG_START_X:   start_x   <= cfg_data;
        rsi_pkg::REG_START_Y:   start_y   <= cfg_data;
        rsi_pkg::REG_THROUGH_X: through_x <= cfg_data;
        rsi_pkg::REG_THROUGH_Y: through_y <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic                                 f_valid;
  logic [DEN_W-1:0]                     f_den;
  logic [rsi_pkg::LANES-1:0][NUM_W-1:0] f_num;
  logic [SIDE_W-1:0]                    f_side;

  rsi_front #(.COORD_WIDTH(W), .Q_W(QW)) u_front (
    .clk, .rst, .en,
    .in_valid  (s_tvalid),
    .seg_a_x   (s_tdata[W-1:0]),
    .seg_a_y   (s_tdata[2*W-1:W]),
    .seg_b_x   (s_tdata[3*W-1:2*W]),
    .seg_b_y   (s_tdata[4*W-1:3*W]),
    .start_x, .start_y, .through_x, .through_y,
    .out_valid (f_valid),
    .den       (f_den),
    .num       (f_num),
    .side      (f_side)
  );

  logic                                 d_valid;
  logic [rsi_pkg::LANES-1:0][QW-1:0]    d_quo;
  logic [SIDE_W-1:0]                    d_side;

  rsi_div #(.DEN_W(DEN_W), .Q_W(QW), .SIDE_W(SIDE_W)) u_div (
    .clk, .rst, .en,
    .in_valid  (f_valid),
    .den       (f_den),
    .num       (f_num),
    .side_in   (f_side),
    .out_valid (d_valid),
    .quo       (d_quo),
    .side_out  (d_side)
  );

  // Final stage: signed offsets along the segment, saturation, zeroing.
  rsi_pkg::outcome_t   d_oc;
  logic signed [W-1:0] d_ax, d_ay;
  logic                d_negx, d_negy, d_sat;
  logic signed [W:0]   qx, qy;
  logic signed [W-1:0] hx, hy;

  assign d_oc   = rsi_pkg::outcome_t'(d_side[1:0]);
  assign d_ax   = d_side[W+1:2];
  assign d_ay   = d_side[2*W+1:W+2];
  assign d_negx = d_side[2*W+2];
  assign d_negy = d_side[2*W+3];
  assign d_sat  = d_side[2*W+4];
  assign qx     = {1'b0, d_quo[rsi_pkg::LANE_X][W-1:0]};
  assign qy     = {1'b0, d_quo[rsi_pkg::LANE_Y][W-1:0]};
  assign hx     = W'((W+1)'(d_ax) + (d_negx ? -qx : qx));
  assign hy     = W'((W+1)'(d_ay) + (d_negy ? -qy : qy));

  rsi_pkg::outcome_t outcome;
  logic signed [W-1:0] hit_x, hit_y;
  logic [QW-1:0]       ray_distance;

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= d_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      outcome <= d_oc;
      if (d_oc == rsi_pkg::OUT_HIT) begin
        hit_x        <= hx;
        hit_y        <= hy;
        ray_distance <= d_sat ? '1 : d_quo[rsi_pkg::LANE_U];
      end else begin
        hit_x        <= '0;
        hit_y        <= '0;
        ray_distance <= '0;
      end
    end
  end

  assign m_tdata = OUT_TW'({ray_distance, hit_y, hit_x, outcome});

  `ASSERT_IMPLY(a_miss_zero, clk, rst,
    m_tvalid && (outcome != rsi_pkg::OUT_HIT),
    (hit_x == '0) && (hit_y == '0) && (ray_distance == '0))
  `ASSERT_NEXT(a_div_to_out, clk, rst, en && d_valid, m_tvalid)
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid && !d_valid && !f_valid)

endmodule

FILE: design/rsi_front.sv
// Front stages: differences, cross products, determinants, sign fix-up and
// classification, and the scaled numerators for the divider. Uses rsi_pkg.
module rsi_front #(
  parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
  parameter int Q_W         = rsi_pkg::DIST_W,
  localparam int DEN_W      = 2 * COORD_WIDTH + 1,
  localparam int NUM_W      = DEN_W + Q_W,
  localparam int SIDE_W     = 2 * COORD_WIDTH + 5
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         en,
  input  logic                                         in_valid,
  input  logic signed [COORD_WIDTH-1:0]                seg_a_x,
  input  logic signed [COORD_WIDTH-1:0]                seg_a_y,
  input  logic signed [COORD_WIDTH-1:0]                seg_b_x,
  input  logic signed [COORD_WIDTH-1:0]                seg_b_y,
  input  logic signed [COORD_WIDTH-1:0]                start_x,
  input  logic signed [COORD_WIDTH-1:0]                start_y,
  input  logic signed [COORD_WIDTH-1:0]                through_x,
  input  logic signed [COORD_WIDTH-1:0]                through_y,
  output logic                                         out_valid,
  output logic [DEN_W-1:0]                             den,
  output logic [rsi_pkg::LANES-1:0][NUM_W-1:0]         num,
  output logic [SIDE_W-1:0]                            side
);

  localparam int W   = COORD_WIDTH;
  localparam int DW  = W + 1;
  localparam int PW  = 2 * W + 2;
  localparam int MW  = DEN_W + W;
  localparam int FR  = rsi_pkg::DIST_FRAC;

  // Stage 1: coordinate differences.
  logic                 s1_v;
  logic signed [DW-1:0] s1_dabx, s1_daby, s1_drx, s1_dry, s1_dasx, s1_dasy;
  logic signed [W-1:0]  s1_ax, s1_ay;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dabx <= DW'(seg_a_x) - DW'(seg_b_x);
      s1_daby <= DW'(seg_a_y) - DW'(seg_b_y);
      s1_drx  <= DW'(start_x) - DW'(through_x);
      s1_dry  <= DW'(start_y) - DW'(through_y);
      s1_dasx <= DW'(seg_a_x) - DW'(start_x);
      s1_dasy <= DW'(seg_a_y) - DW'(start_y);
      s1_ax   <= seg_a_x;
      s1_ay   <= seg_a_y;
    end
  end

  // Stage 2: six cross products.
  logic                 s2_v;
  logic signed [PW-1:0] s2_p0, s2_p1, s2_p2, s2_p3, s2_p4, s2_p5;
  logic signed [DW-1:0] s2_dabx, s2_daby;
  logic signed [W-1:0]  s2_ax, s2_ay;

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p0   <= PW'(s1_dabx) * PW'(s1_dry);
      s2_p1   <= PW'(s1_daby) * PW'(s1_drx);
      s2_p2   <= PW'(s1_dasx) * PW'(s1_dry);
      s2_p3   <= PW'(s1_dasy) * PW'(s1_drx);
      s2_p4   <= PW'(s1_dasx) * PW'(s1_daby);
      s2_p5   <= PW'(s1_dasy) * PW'(s1_dabx);
      s2_dabx <= s1_dabx;
      s2_daby <= s1_daby;
      s2_ax   <= s1_ax;
      s2_ay   <= s1_ay;
    end
  end

  // Stage 3: determinant and the two numerators.
  logic                 s3_v;
  logic signed [PW-1:0] s3_den, s3_tn, s3_un;
  logic signed [DW-1:0] s3_dabx, s3_daby;
  logic signed [W-1:0]  s3_ax, s3_ay;

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= s2_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_den  <= s2_p0 - s2_p1;
      s3_tn   <= s2_p2 - s2_p3;
      s3_un   <= s2_p4 - s2_p5;
      s3_dabx <= s2_dabx;
      s3_daby <= s2_daby;
      s3_ax   <= s2_ax;
      s3_ay   <= s2_ay;
    end
  end

  // Stage 4: make the determinant positive and take segment direction apart
  // into magnitude and sign (the direction is B - A, the negated difference).
  logic                 s4_v;
  logic signed [PW-1:0] s4_den, s4_tn, s4_un;
  logic                 s4_zero;
  logic [W-1:0]         s4_mx, s4_my;
  logic                 s4_negx, s4_negy;
  logic signed [W-1:0]  s4_ax, s4_ay;
  logic                 den_neg;
  logic signed [DW-1:0] abs_x, abs_y;

  assign den_neg = s3_den[PW-1];
  assign abs_x   = s3_dabx[DW-1] ? -s3_dabx : s3_dabx;
  assign abs_y   = s3_daby[DW-1] ? -s3_daby : s3_daby;

  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (en) s4_v <= s3_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_den  <= den_neg ? -s3_den : s3_den;
      s4_tn   <= den_neg ? -s3_tn : s3_tn;
      s4_un   <= den_neg ? -s3_un : s3_un;
      s4_zero <= (s3_den == '0);
      s4_mx   <= abs_x[W-1:0];
      s4_my   <= abs_y[W-1:0];
      s4_negx <= !s3_dabx[DW-1] && (s3_dabx != '0);
      s4_negy <= !s3_daby[DW-1] && (s3_daby != '0);
      s4_ax   <= s3_ax;
      s4_ay   <= s3_ay;
    end
  end

  // Stage 5: classify, detect distance overflow, scale the numerators.
  rsi_pkg::outcome_t oc;
  logic              sat;
  logic [DEN_W-1:0]  den_u, tn_u, un_u;
  logic [MW-1:0]     px, py;

  assign den_u = s4_den[DEN_W-1:0];
  assign tn_u  = s4_tn[DEN_W-1:0];
  assign un_u  = s4_un[DEN_W-1:0];
  assign px    = MW'(tn_u) * MW'(s4_mx);
  assign py    = MW'(tn_u) * MW'(s4_my);
  assign sat   = {{FR{1'b0}}, un_u} >= {den_u, {FR{1'b0}}};

  always_comb begin
    if (s4_zero) oc = rsi_pkg::OUT_PARALLEL;
    else if (s4_tn[PW-1] || (s4_tn > s4_den)) oc = rsi_pkg::OUT_OUTSIDE;
    else if (s4_un[PW-1] || (s4_un == '0)) oc = rsi_pkg::OUT_BEHIND;
    else oc = rsi_pkg::OUT_HIT;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= s4_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den                 <= den_u;
      num[rsi_pkg::LANE_X] <= NUM_W'(px);
      num[rsi_pkg::LANE_Y] <= NUM_W'(py);
      // An overflowing distance is replaced by all ones later; a zero dividend
      // keeps the divider remainder in range.
      num[rsi_pkg::LANE_U] <= sat ? '0 : NUM_W'({un_u, {FR{1'b0}}});
      side <= {sat, s4_negy, s4_negx, s4_ay, s4_ax, oc};
    end
  end

endmodule

FILE: design/rsi_div.sv
// Pipelined restoring divider: one quotient bit per stage, several lanes that
// share one denominator, with side data carried along. Uses rsi_pkg.
module rsi_div #(
  parameter int DEN_W  = 33,
  parameter int Q_W    = rsi_pkg::DIST_W,
  parameter int SIDE_W = 37,
  localparam int NUM_W = DEN_W + Q_W
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [DEN_W-1:0]                     den,
  input  logic [rsi_pkg::LANES-1:0][NUM_W-1:0] num,
  input  logic [SIDE_W-1:0]                    side_in,
  output logic                                 out_valid,
  output logic [rsi_pkg::LANES-1:0][Q_W-1:0]   quo,
  output logic [SIDE_W-1:0]                    side_out
);

  localparam int L = rsi_pkg::LANES;

  // The dividend's upper part must be below den, which holds whenever the
  // quotient fits Q_W bits.
  logic                         vld  [0:Q_W];
  logic [DEN_W-1:0]             dens [0:Q_W];
  logic [SIDE_W-1:0]            sd   [0:Q_W];
  logic [L-1:0][DEN_W-1:0]      rem  [0:Q_W];
  logic [L-1:0][Q_W-1:0]        lo   [0:Q_W];
  logic [L-1:0][Q_W-1:0]        qt   [0:Q_W];

  assign vld[0]  = in_valid;
  assign dens[0] = den;
  assign sd[0]   = side_in;

  for (genvar l = 0; l < L; l++) begin : g_in
    assign rem[0][l] = num[l][NUM_W-1:Q_W];
    assign lo[0][l]  = num[l][Q_W-1:0];
    assign qt[0][l]  = '0;
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [L-1:0][DEN_W:0]   trial;
    logic [L-1:0][DEN_W:0]   diff;
    logic [L-1:0]            take;

    for (genvar l = 0; l < L; l++) begin : g_lane
      assign trial[l] = {rem[k][l], lo[k][l][Q_W-1]};
      assign diff[l]  = trial[l] - {1'b0, dens[k]};
      assign take[l]  = (trial[l] >= {1'b0, dens[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= vld[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dens[k+1] <= dens[k];
        sd[k+1]   <= sd[k];
        for (int l = 0; l < L; l++) begin
          rem[k+1][l] <= take[l] ? diff[l][DEN_W-1:0] : trial[l][DEN_W-1:0];
          lo[k+1][l]  <= lo[k][l] << 1;
          qt[k+1][l]  <= {qt[k][l][Q_W-2:0], take[l]};
        end
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign quo       = qt[Q_W];
  assign side_out  = sd[Q_W];

endmodule

FILE: sim/tb_top.sv
// Self-checking bench for ray_segment_intersection: streams wall segments
// against several ray settings and checks each result beat. Uses rsi_pkg.
`timescale 1ns / 1ps

module tb_top;

  localparam int CW = 16;

  typedef struct packed {
    logic [31:0]        distance;
    logic [CW-1:0]      hy;
    logic [CW-1:0]      hx;
    rsi_pkg::outcome_t  outcome;
  } hit_res_t;

  class hit_board;
    hit_res_t       pending[$];
    logic [CW-1:0]  ray_reg[4];
    int             errors;
    int             checked;
    int             kind_cnt[4];

    function void set_reg(rsi_pkg::cfg_reg_t idx, logic [CW-1:0] val);
      ray_reg[idx] = val;
    endfunction

    // Exact integer intersection test on numerators and denominator.
    function void note_segment(logic [4*CW-1:0] seg);
      longint ax, ay, bx, by, sx, sy, tx, ty, den, tn, un, hx, hy;
      logic [63:0] uq;
      hit_res_t r;
      ax = $signed(seg[0 +: CW]);
      ay = $signed(seg[CW +: CW]);
      bx = $signed(seg[2*CW +: CW]);
      by = $signed(seg[3*CW +: CW]);
      sx = $signed(ray_reg[rsi_pkg::REG_START_X]);
      sy = $signed(ray_reg[rsi_pkg::REG_START_Y]);
      tx = $signed(ray_reg[rsi_pkg::REG_THROUGH_X]);
      ty = $signed(ray_reg[rsi_pkg::REG_THROUGH_Y]);
      den = (ax - bx) * (sy - ty) - (ay - by) * (sx - tx);
      tn = (ax - sx) * (sy - ty) - (ay - sy) * (sx - tx);
      un = (ax - sx) * (ay - by) - (ay - sy) * (ax - bx);
      r = '0;
      if (den == 0) begin
        r.outcome = rsi_pkg::OUT_PARALLEL;
      end else begin
        if (den < 0) begin
          den = -den;
          tn = -tn;
          un = -un;
        end
        if (tn < 0 || tn > den) begin
          r.outcome = rsi_pkg::OUT_OUTSIDE;
        end else if (un <= 0) begin
          r.outcome = rsi_pkg::OUT_BEHIND;
        end else begin
          hx = ax + (tn * (bx - ax)) / den;
          hy = ay + (tn * (by - ay)) / den;
          uq = (64'(un) << 16) / 64'(den);
          if (uq > 64'hFFFF_FFFF) uq = 64'hFFFF_FFFF;
          r.outcome = rsi_pkg::OUT_HIT;
          r.hx = hx[CW-1:0];
          r.hy = hy[CW-1:0];
          r.distance = uq[31:0];
        end
      end
      kind_cnt[r.outcome]++;
      pending.push_back(r);
    endfunction

    function void check_result(logic [65:0] beat);
      hit_res_t got, want;
      got = hit_res_t'(beat);
      if (pending.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual %h", $time, beat);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.outcome !== want.outcome) begin
        $display("%0t outcome: expected %0d, actual %0d", $time, want.outcome, got.outcome);
        errors++;
      end
      if (got.hx !== want.hx) begin
        $display("%0t hit_x: expected %h, actual %h", $time, want.hx, got.hx);
        errors++;
      end
      if (got.hy !== want.hy) begin
        $display("%0t hit_y: expected %h, actual %h", $time, want.hy, got.hy);
        errors++;
      end
      if (got.distance !== want.distance) begin
        $display("%0t ray_distance: expected %h, actual %h", $time,
                 want.distance, got.distance);
        errors++;
      end
    endfunction
  endclass

  logic            clk = 0;
  logic            rst = 1;
  logic            s_tvalid = 0;
  logic            s_tready;
  logic [63:0]     s_tdata = '0;
  logic            m_tvalid;
  logic            m_tready = 0;
  logic [71:0]     m_tdata;
  logic            cfg_we = 0;
  logic [rsi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0]   cfg_data = '0;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  hit_board board = new();

  always #2 clk = ~clk;

  ray_segment_intersection uut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .cfg_we, .cfg_index, .cfg_data
  );

  // Receiver: random stalls, results checked at the rising edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata[65:0]);
  end
  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic write_reg(rsi_pkg::cfg_reg_t idx, logic [CW-1:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_ray(logic [CW-1:0] sx, sy, tx, ty);
    write_reg(rsi_pkg::REG_START_X, sx);
    write_reg(rsi_pkg::REG_START_Y, sy);
    write_reg(rsi_pkg::REG_THROUGH_X, tx);
    write_reg(rsi_pkg::REG_THROUGH_Y, ty);
  endtask

  // Drives one segment beat; valid stays high across back-to-back beats.
  task automatic send_segment(logic [CW-1:0] ax, ay, bx, by);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {by, bx, ay, ax};
    board.note_segment({by, bx, ay, ax});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  function automatic logic [CW-1:0] rnd_coord(int mode);
    case (mode)
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(800)) - 400);
      default: return CW'($signed($urandom_range(64)) - 32);
    endcase
  endfunction

  // Segment straddling the ray line, so most beats reach the hit path.
  task automatic crossing_segment(int mode);
    logic [CW-1:0] ax, ay, bx, by;
    int sx, sy, tx, ty, k, px, py, ox, oy;
    sx = $signed(board.ray_reg[rsi_pkg::REG_START_X]);
    sy = $signed(board.ray_reg[rsi_pkg::REG_START_Y]);
    tx = $signed(board.ray_reg[rsi_pkg::REG_THROUGH_X]);
    ty = $signed(board.ray_reg[rsi_pkg::REG_THROUGH_Y]);
    k = $urandom_range(6);
    px = sx + (tx - sx) * k / 2;
    py = sy + (ty - sy) * k / 2;
    ox = $signed($urandom_range(600)) - 300;
    oy = $signed($urandom_range(600)) - 300;
    ax = CW'(px + ox);
    ay = CW'(py + oy);
    bx = CW'(px - ox);
    by = CW'(py - oy);
    if (mode == 0) begin
      ax = rnd_coord(0);
      by = rnd_coord(0);
    end
    send_segment(ax, ay, bx, by);
  endtask

  task automatic random_phase(int count);
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(9);
      if (mode < 7) crossing_segment(1);
      else if (mode == 7) crossing_segment(0);
      else send_segment(rnd_coord(0), rnd_coord(0), rnd_coord(0), rnd_coord(0));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: ray from origin along +x, through (16,0).
    set_ray(16'sd0, 16'sd0, 16'sd16, 16'sd0);
    send_segment(16'sd32, -16'sd16, 16'sd32, 16'sd16);      // plain hit
    send_segment(-16'sd32, -16'sd16, -16'sd32, 16'sd16);    // behind the ray
    send_segment(16'sd32, 16'sd16, 16'sd32, 16'sd48);       // outside segment
    send_segment(-16'sd32, 16'sd16, -16'sd32, 16'sd48);     // outside and behind
    send_segment(16'sd0, 16'sd5, 16'sd64, 16'sd5);          // parallel
    send_segment(16'sd0, 16'sd0, 16'sd64, 16'sd0);          // coincident
    send_segment(16'sd40, 16'sd7, 16'sd40, 16'sd7);         // point segment
    send_segment(16'sd32, 16'sd0, 16'sd32, 16'sd16);        // endpoint on ray
    send_segment(16'sd32, -16'sd16, 16'sd32, 16'sd0);       // other endpoint
    send_segment(16'sd0, -16'sd16, 16'sd0, 16'sd16);        // through the origin
    send_segment(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    send_segment(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    send_segment(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
    send_segment(16'sd7, -16'sd3, 16'sd41, 16'sd11);        // inexact division
    drain();
    // Degenerate ray: start equals through point.
    set_ray(16'sd100, -16'sd50, 16'sd100, -16'sd50);
    send_segment(16'sd0, 16'sd0, 16'sd64, 16'sd64);
    drain();
    // Extreme ray, huge distance scale and tiny u.
    set_ray(16'sh8000, 16'sh8000, 16'sh8001, 16'sh8000);
    send_segment(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF);
    send_segment(16'sh8001, 16'sh7FFF, 16'sh8001, 16'sh8000);
    drain();
    set_ray(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
    send_segment(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    send_segment(16'sh7FFE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFE);
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      send_idle_pct = (phase % 3 == 0) ? 38 : (phase % 3 == 1) ? 64 : 0;
      recv_idle_pct = (phase % 3 == 0) ? 64 : (phase % 3 == 1) ? 38 : 0;
      if (phase == 8) set_ray(rnd_coord(0), rnd_coord(0), rnd_coord(0), rnd_coord(0));
      else set_ray(rnd_coord(phase % 2 + 1), rnd_coord(1), rnd_coord(phase % 2 + 1),
                   rnd_coord(2));
      random_phase(140);
      drain();
    end

    $display("Checked %0d beats over 13 ray settings: %0d hits, %0d parallel,",
             board.checked, board.kind_cnt[rsi_pkg::OUT_HIT],
             board.kind_cnt[rsi_pkg::OUT_PARALLEL]);
    $display("%0d outside segment, %0d behind ray.",
             board.kind_cnt[rsi_pkg::OUT_OUTSIDE], board.kind_cnt[rsi_pkg::OUT_BEHIND]);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: files.f
+incdir+design
design/rsi_pkg.sv
design/rsi_front.sv
design/rsi_div.sv
design/ray_segment_intersection.sv
sim/tb_top.sv
